// ===== rtl/vgrt_pkg.sv =====
// shared constants, types and codes for the voxel grid ray traversal block
package vgrt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VOX_BITS  = 16;
  localparam int POS_W     = 32;
  localparam int DIR_W     = 24;
  localparam int DIST_W    = 24;
  localparam int CROSS_W   = 32;
  localparam int SQ_W      = 2 * DIR_W;
  localparam int LEN_W     = SQ_W / 2;
  localparam int BND_W     = FRAC_BITS + 1;
  localparam int DIV_W     = BND_W + LEN_W;
  localparam int DVS_W     = DIR_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int SQRT_CNT_W = $clog2(LEN_W + 1);

  localparam logic [1:0] KIND_QUERY = 2'd0;
  localparam logic [1:0] KIND_HIT   = 2'd1;
  localparam logic [1:0] KIND_MISS  = 2'd2;

  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_ANSWER = 1'b1;

  localparam logic signed [1:0] FACE_POS  = 2'sb01;
  localparam logic signed [1:0] FACE_NEG  = 2'sb11;
  localparam logic signed [1:0] FACE_NONE = 2'sb00;

  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [DVS_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_W-1:0]   quotient;
  } div_rsp_t;

endpackage

// ===== rtl/vgrt_isqrt.sv =====
// iterative integer square root, two radicand bits per cycle
module vgrt_isqrt import vgrt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SQ_W-1:0]  radicand_i,
  output logic             done_o,
  output logic [LEN_W-1:0] root_o
);

  logic [SQ_W-1:0]       rad_q, rad_d;
  logic [LEN_W+1:0]      rem_q, rem_d;
  logic [LEN_W-1:0]      root_q, root_d;
  logic [SQRT_CNT_W-1:0] cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [LEN_W+3:0]      rem_sh;
  logic [LEN_W+3:0]      trial;

  always_comb begin
    rem_sh = {rem_q, rad_q[SQ_W-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[SQ_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = LEN_W'(0) | (LEN_W+2)'(rem_sh - trial);
        root_d = {root_q[LEN_W-2:0], 1'b1};
      end else begin
        rem_d  = (LEN_W+2)'(rem_sh);
        root_d = {root_q[LEN_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == SQRT_CNT_W'(LEN_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== rtl/vgrt_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module vgrt_div import vgrt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DVS_W-1:0]     rem_q, rem_d;
  logic [DVS_W-1:0]     dvs_q, dvs_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DVS_W:0]       rem_sh;
  logic                 ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[DIV_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? DVS_W'(rem_sh - {1'b0, dvs_q}) : DVS_W'(rem_sh);
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |-> !busy_q)
    else $error("divider restarted while busy");

endmodule

// ===== rtl/voxel_grid_ray_traversal_top.sv =====
// top level: ray setup sequencer and voxel stepping for 3d grid traversal
// start to result valid: squaring, root launch, root wait, then per nonzero axis a multiply
//   and two 41-step divisions on the one shared divider, or a skip per zero axis, then result
//   load; the total is set by the bit-serial root and the divisions
// non-solid answer: axis pick, reach check and step, then result load; hit and
//   zero-direction miss: result load only; answer without a ray gives no result and is done at once
// input stalls until the result is loaded, a new request is taken the cycle after
// rst_ni clears the sequencer, the ray state and the output valid asynchronously
module voxel_grid_ray_traversal_top import vgrt_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      action_i,
  input  logic signed [POS_W-1:0]   origin_x_i,
  input  logic signed [POS_W-1:0]   origin_y_i,
  input  logic signed [POS_W-1:0]   origin_z_i,
  input  logic signed [DIR_W-1:0]   dir_x_i,
  input  logic signed [DIR_W-1:0]   dir_y_i,
  input  logic signed [DIR_W-1:0]   dir_z_i,
  input  logic [DIST_W-1:0]         reach_i,
  input  logic                      solid_answer_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                kind_o,
  output logic signed [15:0]        voxel_x_o,
  output logic signed [15:0]        voxel_y_o,
  output logic signed [15:0]        voxel_z_o,
  output logic signed [1:0]         face_x_o,
  output logic signed [1:0]         face_y_o,
  output logic signed [1:0]         face_z_o,
  output logic [DIST_W-1:0]         hit_distance_o
);

  // sequencer states
  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_SQ     = 13'b0000000000010,
    S_RGO    = 13'b0000000000100,
    S_RWAIT  = 13'b0000000001000,
    S_AXIS   = 13'b0000000010000,
    S_CSGO   = 13'b0000000100000,
    S_CSWAIT = 13'b0000001000000,
    S_MUL    = 13'b0000010000000,
    S_NCGO   = 13'b0000100000000,
    S_NCWAIT = 13'b0001000000000,
    S_SEL    = 13'b0010000000000,
    S_ADV    = 13'b0100000000000,
    S_EMIT   = 13'b1000000000000
  } state_e;

  localparam logic [CROSS_W-1:0] SAT = '1;
  localparam logic [BND_W-1:0]   ONE_FX = BND_W'(1) << FRAC_BITS;

  state_e state_q, state_d;

  // ray state
  logic                    active_q, active_d;
  logic [VOX_BITS-1:0]     vox_q [3];
  logic [VOX_BITS-1:0]     vox_d [3];
  logic [2:0]              signs_q, signs_d;
  logic [CROSS_W-1:0]      nc_q [3];
  logic [CROSS_W-1:0]      nc_d [3];
  logic [CROSS_W-1:0]      cs_q [3];
  logic [CROSS_W-1:0]      cs_d [3];
  logic [DIST_W-1:0]       reach_q, reach_d;
  logic [DIST_W-1:0]       trav_q, trav_d;
  logic [2:0]              face_q, face_d;

  // setup working registers
  logic signed [DIR_W-1:0] dir_q [3];
  logic signed [DIR_W-1:0] dir_d [3];
  logic [FRAC_BITS-1:0]    fr_q [3];
  logic [FRAC_BITS-1:0]    fr_d [3];
  logic [1:0]              cnt_q, cnt_d;
  logic [SQ_W-1:0]         sq_q, sq_d;
  logic [SQ_W-1:0]         prod_q, prod_d;
  logic [LEN_W-1:0]        len_q, len_d;
  logic [1:0]              sel_q, sel_d;
  logic [1:0]              kind_q, kind_d;

  // output register
  logic                    ovalid_q, ovalid_d;
  logic [1:0]              okind_q, okind_d;
  logic [15:0]             ovox_q [3];
  logic [15:0]             ovox_d [3];
  logic [1:0]              oface_q [3];
  logic [1:0]              oface_d [3];
  logic [DIST_W-1:0]       odist_q, odist_d;

  // shared units
  logic                    root_start;
  logic                    root_done;
  logic [LEN_W-1:0]        root_val;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  // multiplier: squares during setup, boundary times length per axis afterwards
  logic signed [DIR_W:0]   mul_a, mul_b;
  logic signed [2*DIR_W+1:0] mul_p;

  logic signed [DIR_W-1:0] dcur;
  logic [DVS_W-1:0]        mag;
  logic [BND_W-1:0]        bnd;
  logic [CROSS_W-1:0]      qsat;
  logic [CROSS_W-1:0]      ncs;
  logic [CROSS_W:0]        nsum;
  logic                    in_acc;
  logic                    can_emit;

  vgrt_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (sq_q),
    .done_o     (root_done),
    .root_o     (root_val)
  );

  vgrt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign can_emit   = !ovalid_q || !out_stall_i;

  assign dcur = dir_q[cnt_q];
  assign mag  = dcur[DIR_W-1] ? DVS_W'(-dcur) : DVS_W'(dcur);
  // distance to the first boundary along the axis
  assign bnd  = signs_q[cnt_q] ? BND_W'(fr_q[cnt_q]) : ONE_FX - BND_W'(fr_q[cnt_q]);
  assign qsat = (div_rsp.quotient[DIV_W-1:CROSS_W] != '0) ? SAT
                                                          : div_rsp.quotient[CROSS_W-1:0];
  assign ncs  = nc_q[sel_q];
  assign nsum = {1'b0, ncs} + {1'b0, cs_q[sel_q]};

  always_comb begin
    if (state_q == S_MUL) begin
      mul_a = (DIR_W+1)'($signed({1'b0, bnd}));
      mul_b = $signed({1'b0, len_q});
    end else begin
      mul_a = (DIR_W+1)'(dcur);
      mul_b = (DIR_W+1)'(dcur);
    end
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_d  = state_q;
    active_d = active_q;
    vox_d    = vox_q;
    signs_d  = signs_q;
    nc_d     = nc_q;
    cs_d     = cs_q;
    reach_d  = reach_q;
    trav_d   = trav_q;
    face_d   = face_q;
    dir_d    = dir_q;
    fr_d     = fr_q;
    cnt_d    = cnt_q;
    sq_d     = sq_q;
    prod_d   = prod_q;
    len_d    = len_q;
    sel_d    = sel_q;
    kind_d   = kind_q;
    root_start       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'({len_q, FRAC_BITS'(0)});
    div_req.divisor  = mag;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (action_i == ACT_START) begin
            active_d = 1'b0;
            if (dir_x_i == '0 && dir_y_i == '0 && dir_z_i == '0) begin
              kind_d  = KIND_MISS;
              state_d = S_EMIT;
            end else begin
              dir_d[0] = dir_x_i;
              dir_d[1] = dir_y_i;
              dir_d[2] = dir_z_i;
              fr_d[0]  = origin_x_i[FRAC_BITS-1:0];
              fr_d[1]  = origin_y_i[FRAC_BITS-1:0];
              fr_d[2]  = origin_z_i[FRAC_BITS-1:0];
              // floor of the origin is its integer part, wrapped to the voxel width
              vox_d[0] = origin_x_i[FRAC_BITS +: VOX_BITS];
              vox_d[1] = origin_y_i[FRAC_BITS +: VOX_BITS];
              vox_d[2] = origin_z_i[FRAC_BITS +: VOX_BITS];
              reach_d  = reach_i;
              trav_d   = '0;
              face_d   = '0;
              signs_d  = '0;
              sq_d     = '0;
              cnt_d    = '0;
              state_d  = S_SQ;
            end
          end else if (active_q) begin
            if (solid_answer_i) begin
              active_d = 1'b0;
              kind_d   = KIND_HIT;
              state_d  = S_EMIT;
            end else begin
              state_d = S_SEL;
            end
          end
        end
      end
      // squares go through the multiplier one axis per cycle into a product register, which feeds the sum
      S_SQ: begin
        prod_d = SQ_W'(mul_p);
        if (cnt_q != 2'd0) begin
          sq_d = sq_q + prod_q;
        end
        if (cnt_q == 2'd3) begin
          cnt_d   = '0;
          state_d = S_RGO;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_RGO: begin
        root_start = 1'b1;
        state_d    = S_RWAIT;
      end
      S_RWAIT: begin
        if (root_done) begin
          len_d   = root_val;
          state_d = S_AXIS;
        end
      end
      S_AXIS: begin
        if (dcur == '0) begin
          nc_d[cnt_q] = SAT;
          cs_d[cnt_q] = SAT;
          if (cnt_q == 2'd2) begin
            active_d = 1'b1;
            kind_d   = KIND_QUERY;
            state_d  = S_EMIT;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end else begin
          signs_d[cnt_q] = dcur[DIR_W-1];
          state_d        = S_CSGO;
        end
      end
      S_CSGO: begin
        div_req.start = 1'b1;
        state_d       = S_CSWAIT;
      end
      S_CSWAIT: begin
        if (div_rsp.done) begin
          cs_d[cnt_q] = qsat;
          state_d     = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = SQ_W'(mul_p);
        state_d = S_NCGO;
      end
      S_NCGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(prod_q);
        state_d          = S_NCWAIT;
      end
      S_NCWAIT: begin
        if (div_rsp.done) begin
          nc_d[cnt_q] = qsat;
          if (cnt_q == 2'd2) begin
            active_d = 1'b1;
            kind_d   = KIND_QUERY;
            state_d  = S_EMIT;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            state_d = S_AXIS;
          end
        end
      end
      // nearest boundary, a tie goes to the later axis: z over y, y over x
      S_SEL: begin
        if (nc_q[0] < nc_q[1]) begin
          sel_d = (nc_q[0] < nc_q[2]) ? 2'd0 : 2'd2;
        end else begin
          sel_d = (nc_q[1] < nc_q[2]) ? 2'd1 : 2'd2;
        end
        state_d = S_ADV;
      end
      S_ADV: begin
        if (ncs > CROSS_W'(reach_q)) begin
          active_d = 1'b0;
          kind_d   = KIND_MISS;
        end else begin
          trav_d = ncs[DIST_W-1:0];
          if (signs_q[sel_q]) begin
            vox_d[sel_q] = vox_q[sel_q] - 1'b1;
            face_d       = {1'b1, sel_q + 2'd1};
          end else begin
            vox_d[sel_q] = vox_q[sel_q] + 1'b1;
            face_d       = {1'b0, sel_q + 2'd1};
          end
          nc_d[sel_q] = nsum[CROSS_W] ? SAT : nsum[CROSS_W-1:0];
          kind_d      = KIND_QUERY;
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (can_emit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result register, loaded from the ray state when the slot is free
  always_comb begin
    ovalid_d = ovalid_q;
    okind_d  = okind_q;
    ovox_d   = ovox_q;
    oface_d  = oface_q;
    odist_d  = odist_q;
    if (ovalid_q && !out_stall_i) begin
      ovalid_d = 1'b0;
    end
    if (state_q == S_EMIT && can_emit) begin
      ovalid_d = 1'b1;
      okind_d  = kind_q;
      for (int a = 0; a < 3; a++) begin
        if (kind_q == KIND_MISS) begin
          ovox_d[a]  = '0;
          oface_d[a] = FACE_NONE;
        end else begin
          ovox_d[a]  = 16'($signed(vox_q[a]));
          oface_d[a] = (face_q[1:0] == 2'(a + 1)) ? (face_q[2] ? FACE_POS : FACE_NEG)
                                                    : FACE_NONE;
        end
      end
      odist_d = (kind_q == KIND_MISS) ? '0 : trav_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      active_q <= 1'b0;
      ovalid_q <= 1'b0;
      signs_q  <= '0;
      reach_q  <= '0;
      trav_q   <= '0;
      face_q   <= '0;
      cnt_q    <= '0;
      for (int a = 0; a < 3; a++) begin
        vox_q[a] <= '0;
        nc_q[a]  <= '0;
        cs_q[a]  <= '0;
      end
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      ovalid_q <= ovalid_d;
      signs_q  <= signs_d;
      reach_q  <= reach_d;
      trav_q   <= trav_d;
      face_q   <= face_d;
      cnt_q    <= cnt_d;
      vox_q    <= vox_d;
      nc_q     <= nc_d;
      cs_q     <= cs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dir_q   <= dir_d;
    fr_q    <= fr_d;
    sq_q    <= sq_d;
    prod_q  <= prod_d;
    len_q   <= len_d;
    sel_q   <= sel_d;
    kind_q  <= kind_d;
    okind_q <= okind_d;
    ovox_q  <= ovox_d;
    oface_q <= oface_d;
    odist_q <= odist_d;
  end

  assign out_valid_o    = ovalid_q;
  assign kind_o         = okind_q;
  assign voxel_x_o      = ovox_q[0];
  assign voxel_y_o      = ovox_q[1];
  assign voxel_z_o      = ovox_q[2];
  assign face_x_o       = oface_q[0];
  assign face_y_o       = oface_q[1];
  assign face_z_o       = oface_q[2];
  assign hit_distance_o = odist_q;

  // a stepped ray never travels past its reach
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> trav_q <= reach_q)
    else $error("travelled distance beyond reach");

  // a miss carries no face or distance; its zeroed voxel is not checked here
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_MISS) |-> (hit_distance_o == '0 && face_x_o == '0
      && face_y_o == '0 && face_z_o == '0))
    else $error("miss result with payload");

  // at most one face component is set at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($countones({face_x_o != '0, face_y_o != '0, face_z_o != '0}) <= 1))
    else $error("more than one face normal component");

  // the square root is started only once the sum of squares is complete
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_start |-> $past(state_q == S_SQ))
    else $error("square root started early");

endmodule
